// ===== hdl/key_matrix_debounce_scanner_core_defines.svh =====
// Assertion macros shared by the key matrix scanner RTL.
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_CORE_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_CORE_DEFINES_SVH

// Both macros sample on i_clk and stay quiet while i_rst_n is low.

// Checks that the consequent holds in the same cycle as the antecedent.
`define KMDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KMDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kmds_pkg.sv =====
// Shared constants and types of the key matrix scanner.
package kmds_pkg;

    // Matrix geometry and time width.
    localparam int COLUMNS   = 14;
    localparam int ROWS      = 5;
    localparam int TIME_BITS = 32;

    // Fixed field widths of the stream beats.
    localparam int COL_W   = 4;
    localparam int LVL_W   = 5;
    localparam int NOW_W   = 32;
    localparam int ROW_W   = 3;
    localparam int DEB_W   = 8;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    // Address width of the per-column state memory.
    localparam int MEM_AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);

    // One memory word holds the debounced bits and change times of one column.
    typedef struct packed {
        logic [ROWS-1:0][TIME_BITS-1:0] times;
        logic [ROWS-1:0]                keys;
    } t_entry;

endpackage

// ===== hdl/key_matrix_debounce_scanner_core.sv =====
// Top level of the key matrix scanner with per-key debounce.
`include "key_matrix_debounce_scanner_core_defines.svh"

// Each input beat carries the sampled row levels of one driven column and the
// current millisecond time. The debounced key bits and last-change times of a
// column live together in one word of a synchronous memory of COLUMNS words.
// A beat is read from memory in the cycle it is accepted, then evaluated and
// written back in the first following cycle in which the event output is free,
// and the resulting change events leave one per cycle while the sink accepts
// them, from an event register, in ascending row order, with the final one
// marked by tlast. The next beat waits in the evaluation stage until the last
// event of the one before is taken, so that single event output sets the
// sustained rate; a sample that causes no event holds nothing up. A read that
// hits the column being written in the same cycle takes the new word directly.
// There is no clearing pass after reset: one valid bit per column makes an
// unwritten word read as all zeros, so the block takes beats right after reset.
// A column index of COLUMNS or above is accepted and ignored.
module key_matrix_debounce_scanner_core
    import kmds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: debounce time in milliseconds
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [DEB_W-1:0]    i_cfg_data,
    // Input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // column[3:0], row_levels[8:4], now_ms[40:9]
    // Event stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // event_row[2:0], event_column[6:3], pressed[7]
    output logic                o_m_tlast
);

    // Input beat fields.
    logic [COL_W-1:0]     s_col;
    logic [LVL_W-1:0]     s_levels;
    logic [NOW_W-1:0]     s_now;
    logic                 s_accept;
    logic                 s_in_range;

    assign s_col      = i_s_tdata[COL_W-1:0];
    assign s_levels   = i_s_tdata[COL_W +: LVL_W];
    assign s_now      = i_s_tdata[COL_W+LVL_W +: NOW_W];
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_in_range = 32'(s_col) < COLUMNS;

    // Configuration register.
    logic [DEB_W-1:0] r_debounce;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce <= i_cfg_data;
        end
    end

    // Evaluation stage registers.
    logic                 r_s1_vld;
    logic                 r_s1_inr;
    logic [COL_W-1:0]     r_s1_col;
    logic [LVL_W-1:0]     r_s1_levels;
    logic [TIME_BITS-1:0] r_s1_now;

    // Event register.
    logic [ROWS-1:0]      r_ev_mask;
    logic [ROWS-1:0]      r_ev_levels;
    logic [COL_W-1:0]     r_ev_col;
    logic [ROWS-1:0]      n_ev_mask;

    // Memory and its per-column valid bits.
    t_entry               r_mem [COLUMNS];
    t_entry               r_rd_entry;
    logic                 r_rd_vld;
    logic [COLUMNS-1:0]   r_row_vld;

    logic                 mem_re;
    logic                 mem_we;
    logic                 mem_hit;
    logic [MEM_AW-1:0]    rd_addr;
    logic [MEM_AW-1:0]    wr_addr;
    t_entry               cur_entry;
    t_entry               wr_entry;
    logic [ROWS-1:0]      hit;

    logic                 s1_fire;
    logic                 ev_free;
    logic                 m_accept;
    logic                 m_stall;
    logic [ROWS-1:0]      ev_bit;
    logic [ROW_W-1:0]     ev_row;
    logic                 ev_last;

    assign rd_addr = s_col[MEM_AW-1:0];
    assign wr_addr = r_s1_col[MEM_AW-1:0];
    assign mem_re  = s_accept && s_in_range;
    assign mem_we  = s1_fire && r_s1_inr;
    assign mem_hit = mem_we && (wr_addr == rd_addr);

    // Synchronous memory with write-to-read forwarding on the same column.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (mem_re) begin
            if (mem_hit) begin
                r_rd_entry <= wr_entry;
            end else begin
                r_rd_entry <= r_mem[rd_addr];
            end
        end
    end

    // Valid bits stand in for clearing the memory at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_re) begin
                r_rd_vld <= mem_hit || r_row_vld[rd_addr];
            end
            if (mem_we) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Per-row debounce decision and the updated memory word.
    always_comb begin
        cur_entry = r_rd_vld ? r_rd_entry : '0;
        wr_entry  = cur_entry;
        hit       = '0;
        for (int r = 0; r < ROWS; r++) begin
            hit[r] = r_s1_inr && (r_s1_levels[r] != cur_entry.keys[r]) &&
                     ((r_s1_now - cur_entry.times[r]) > TIME_BITS'(r_debounce));
            if (hit[r]) begin
                wr_entry.keys[r]  = r_s1_levels[r];
                wr_entry.times[r] = r_s1_now;
            end
        end
    end

    // Event selection: lowest pending row first.
    always_comb begin
        ev_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (r_ev_mask[r]) begin
                ev_row = ROW_W'(r);
            end
        end
    end

    assign ev_bit   = r_ev_mask & (~r_ev_mask + ROWS'(1));
    assign ev_last  = (r_ev_mask & ~ev_bit) == '0;
    assign m_accept = o_m_tvalid && i_m_tready;
    assign m_stall  = o_m_tvalid && !i_m_tready;
    assign ev_free  = (r_ev_mask == '0) || (m_accept && ev_last);
    assign s1_fire  = r_s1_vld && ev_free;

    assign o_s_tready = !r_s1_vld || s1_fire;
    assign o_m_tvalid = r_ev_mask != '0;
    assign o_m_tlast  = ev_last;
    assign o_m_tdata  = {|(r_ev_levels & ev_bit), r_ev_col, ev_row};

    always_comb begin
        n_ev_mask = r_ev_mask;
        if (s1_fire) begin
            n_ev_mask = hit;
        end else if (m_accept) begin
            n_ev_mask = r_ev_mask & ~ev_bit;
        end
    end

    // Pipeline control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_ev_mask <= '0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            r_ev_mask <= n_ev_mask;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_inr    <= s_in_range;
            r_s1_col    <= s_col;
            r_s1_levels <= s_levels;
            r_s1_now    <= TIME_BITS'(s_now);
        end
        if (s1_fire) begin
            r_ev_levels <= r_s1_levels[ROWS-1:0];
            r_ev_col    <= r_s1_col;
        end
    end

    // Checks on the block's own control.
    `KMDS_ASSERT_SAME(a_ev_col_range, o_m_tvalid, 32'(r_ev_col) < COLUMNS, "bad event column")
    `KMDS_ASSERT_SAME(a_stall_busy, !o_s_tready, r_s1_vld && !ev_free, "stall while idle")
    `KMDS_ASSERT_NEXT(a_ev_hold, m_stall, r_ev_mask == $past(r_ev_mask), "events moved in stall")

endmodule
